### hw/rtl/aes_pkg.sv
// AES-128 shared types, constants and byte functions.
// Used by the round unit, key expander and top level; no dependencies.
package aes_pkg;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned NumKeys   = NumRounds + 1;

    localparam logic       OpEncrypt = 1'b0;
    localparam logic       OpDecrypt = 1'b1;

    localparam logic       CfgKeyHigh = 1'b0;
    localparam logic       CfgKeyLow  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [63:0] data_high;
        logic [63:0] data_low;
    } t_req;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_rsp;

    // Control from the sequencer to the round unit.
    typedef struct packed {
        logic load;     // take the input block and apply the first key
        logic decrypt;
        logic last;     // final round: no column mix
    } t_rnd_ctl;

    function automatic logic [7:0] sbox_fwd(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [7:0] sbox_inv(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] n);
        logic [7:0] r;
        case (n)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/aes_key_exp.sv
// AES-128 key expander: one 128-bit round key per cycle from the previous one.
// Depends on aes_pkg (sbox_fwd, rcon).
module aes_key_exp (
    input  logic         i_clk,
    input  logic         i_start,
    input  logic [127:0] i_key,
    input  logic [3:0]   i_idx,     // round index of the next key (1..10)
    output logic [127:0] o_rkey
);
    import aes_pkg::*;

    logic [127:0] r_cur;
    logic [127:0] n_cur;
    logic [31:0]  w3;
    logic [31:0]  t;
    logic [31:0]  w0, w1, w2, w3n;

    always_comb begin
        w3  = r_cur[31:0];
        t   = {sbox_fwd(w3[23:16]) ^ rcon(i_idx), sbox_fwd(w3[15:8]),
               sbox_fwd(w3[7:0]), sbox_fwd(w3[31:24])};
        w0  = r_cur[127:96] ^ t;
        w1  = r_cur[95:64] ^ w0;
        w2  = r_cur[63:32] ^ w1;
        w3n = w3 ^ w2;
        n_cur = i_start ? i_key : {w0, w1, w2, w3n};
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    // current round key; the cipher key itself while idle
    assign o_rkey = r_cur;
endmodule

### hw/rtl/aes_round.sv
// AES round unit: one encrypt or decrypt round per cycle on the state register while i_en is high.
// Depends on aes_pkg (t_rnd_ctl, sbox functions, xtime).
module aes_round (
    input  logic                  i_clk,
    input  aes_pkg::t_rnd_ctl     i_ctl,
    input  logic                  i_en,
    input  logic [127:0]          i_block,
    input  logic [127:0]          i_rkey,
    output logic [127:0]          o_state
);
    import aes_pkg::*;

    logic [127:0] r_st;
    logic [127:0] n_st;
    logic [7:0]   b  [16];
    logic [7:0]   s  [16];
    logic [7:0]   k  [16];
    logic [7:0]   m  [16];
    logic [7:0]   c  [4];
    logic [7:0]   e2 [4];
    logic [7:0]   e4 [4];
    logic [7:0]   e8 [4];
    logic [127:0] post;

    // byte j sits at bits 127-8j; j = col*4 + row
    always_comb begin
        for (int j = 0; j < 16; j++) begin
            b[j] = r_st[127 - 8*j -: 8];
        end
        for (int cc = 0; cc < 4; cc++) begin
            for (int rr = 0; rr < 4; rr++) begin
                if (i_ctl.decrypt) begin
                    s[((cc + rr) % 4)*4 + rr] = sbox_inv(b[cc*4 + rr]);
                end else begin
                    s[cc*4 + rr] = sbox_fwd(b[((cc + rr) % 4)*4 + rr]);
                end
            end
        end
        for (int j = 0; j < 16; j++) begin
            k[j] = s[j];
            if (i_ctl.decrypt) begin
                k[j] = s[j] ^ i_rkey[127 - 8*j -: 8];
            end
        end
        // mix columns; decrypt reuses doubling chain for 9, 11, 13, 14
        for (int cc = 0; cc < 4; cc++) begin
            for (int rr = 0; rr < 4; rr++) begin
                c[rr]  = k[cc*4 + rr];
                e2[rr] = xtime(c[rr]);
                e4[rr] = xtime(e2[rr]);
                e8[rr] = xtime(e4[rr]);
            end
            for (int rr = 0; rr < 4; rr++) begin
                if (i_ctl.decrypt) begin
                    m[cc*4 + rr] =
                        (e8[rr] ^ e4[rr] ^ e2[rr]) ^
                        (e8[(rr+1)%4] ^ e2[(rr+1)%4] ^ c[(rr+1)%4]) ^
                        (e8[(rr+2)%4] ^ e4[(rr+2)%4] ^ c[(rr+2)%4]) ^
                        (e8[(rr+3)%4] ^ c[(rr+3)%4]);
                end else begin
                    m[cc*4 + rr] = e2[rr] ^ (e2[(rr+1)%4] ^ c[(rr+1)%4]) ^
                                   c[(rr+2)%4] ^ c[(rr+3)%4];
                end
            end
        end
        for (int j = 0; j < 16; j++) begin
            post[127 - 8*j -: 8] = i_ctl.last ? k[j] : m[j];
        end
        if (!i_ctl.decrypt) begin
            post = post ^ i_rkey;
        end
        if (i_ctl.load) begin
            n_st = i_block ^ i_rkey;
        end else begin
            n_st = post;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_state = r_st;
endmodule

### hw/rtl/aes128_block_cipher.sv
// AES-128 top level: key registers, round-key store, sequencer; results come from the round state register.
// Depends on aes_pkg, aes_key_exp, aes_round.
//
//  channel | direction | handshake          | payload
//  req     | in        | i_valid / o_stall  | i_req  (t_req)
//  rsp     | out       | o_valid / i_stall  | o_rsp  (t_rsp)
//  cfg     | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// An accepted request is loaded with the first key, then runs ten rounds, one
// per cycle on the shared round unit; o_valid rises with the last round's state.
// The next request is taken only after the result has been taken and the block
// is idle again. After reset or a key write the first request first expands
// the keys into the store. o_stall stays high while a request is in work or a
// result waits. Reset is synchronous, active low; the store has no reset.
module aes128_block_cipher (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  aes_pkg::t_req    i_req,
    output logic             o_valid,
    input  logic             i_stall,
    output aes_pkg::t_rsp    o_rsp,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [63:0]      i_cfg_data
);
    import aes_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EXP, S_RUN, S_OUT} t_state;

    t_state        r_state;
    logic [63:0]   r_key_hi, r_key_lo;
    logic          r_ready;
    logic [3:0]    r_cnt;
    logic          r_dec;
    t_req          r_req;
    logic [127:0]  r_mem [NumKeys];
    logic [127:0]  r_rd;
    logic [127:0]  exp_key;
    logic [127:0]  rnd_state;
    logic          accept;
    logic [3:0]    rd_idx;
    logic [3:0]    n_cnt;
    t_rnd_ctl      ctl;
    logic          en;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    aes_key_exp u_kexp (
        .i_clk   (i_clk),
        .i_start (r_state != S_EXP),
        .i_key   ({r_key_hi, r_key_lo}),
        .i_idx   (r_cnt + 4'd1),
        .o_rkey  (exp_key)
    );

    // read address for next cycle's key; round r of decrypt uses key 10-r
    always_comb begin
        n_cnt  = (r_state == S_RUN) ? r_cnt + 4'd1 : 4'd0;
        rd_idx = r_dec ? 4'(NumRounds) - n_cnt : n_cnt;
        if (accept) begin
            rd_idx = i_req.operation ? 4'(NumRounds) : 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXP) begin
            r_mem[r_cnt] <= exp_key;
        end
        // forward the key being written this cycle
        if ((r_state == S_EXP) && (rd_idx == r_cnt)) begin
            r_rd <= exp_key;
        end else begin
            r_rd <= r_mem[rd_idx];
        end
    end

    always_comb begin
        ctl.load    = (r_state == S_RUN) && (r_cnt == 4'd0);
        ctl.decrypt = r_dec;
        ctl.last    = (r_cnt == 4'(NumRounds));
        en          = (r_state == S_RUN);
    end

    aes_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_en    (en),
        .i_block ({r_req.data_high, r_req.data_low}),
        .i_rkey  (r_rd),
        .o_state (rnd_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_ready  <= 1'b0;
            r_cnt    <= '0;
            o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CfgKeyHigh) r_key_hi <= i_cfg_data;
                if (i_cfg_idx == CfgKeyLow)  r_key_lo <= i_cfg_data;
                r_ready <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (accept) begin
                        r_req   <= i_req;
                        r_dec   <= i_req.operation;
                        r_state <= r_ready ? S_RUN : S_EXP;
                    end
                end
                S_EXP: begin
                    if (r_cnt == 4'(NumRounds)) begin
                        r_cnt   <= '0;
                        r_ready <= 1'b1;
                        r_state <= S_RUN;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_RUN: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(NumRounds)) begin
                        r_state <= S_OUT;
                        o_valid <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp = {rnd_state[127:64], rnd_state[63:0]};

    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT) else $error("result without finished request");
    a_run_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> r_ready) else $error("rounds before keys expanded");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> o_stall) else $error("accepting while busy");
endmodule

### sim/aes128_block_cipher_test.sv
// Self-checking testbench for the AES-128 block cipher top level.
// Holds its own AES-128 model for expected blocks; depends on aes_pkg and the RTL.
`timescale 1ns / 100ps

module aes128_block_cipher_test;
    import aes_pkg::*;

    localparam int unsigned IdleLimit = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    t_req        req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    t_rsp        rsp;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = CfgKeyHigh;
    logic [63:0] cfg_data = '0;

    t_rsp        expected_blocks[$];
    logic [63:0] cur_key_high = '0;
    logic [63:0] cur_key_low = '0;
    logic [31:0] key_words[44];
    bit          words_valid = 1'b0;
    int unsigned errors = 0;
    int unsigned blocks_checked = 0;
    int unsigned requests_sent = 0;
    int unsigned idle_cycles = 0;
    bit          hold_long = 1'b0;
    bit          rsp_gaps = 1'b1;

    aes128_block_cipher u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .o_stall(req_stall), .i_req(req),
        .o_valid(rsp_valid), .i_stall(rsp_stall), .o_rsp(rsp),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- AES predictor ----------------
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] m);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (m[k]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [7:0] fwd_sub(input logic [7:0] a);
        logic [7:0] inv;
        logic [7:0] p;
        logic [7:0] r;
        inv = 8'h00;
        // multiplicative inverse by brute force, then the affine map
        for (int x = 1; x < 256; x++) begin
            if (gf_mul(a, x[7:0]) == 8'h01) inv = x[7:0];
        end
        p = inv;
        r = p ^ {p[6:0], p[7]} ^ {p[5:0], p[7:6]} ^ {p[4:0], p[7:5]}
              ^ {p[3:0], p[7:4]} ^ 8'h63;
        return r;
    endfunction

    logic [7:0] sub_tab[256];
    logic [7:0] inv_sub_tab[256];

    task automatic build_sub_tables();
        for (int i = 0; i < 256; i++) begin
            sub_tab[i] = fwd_sub(i[7:0]);
            inv_sub_tab[sub_tab[i]] = i[7:0];
        end
    endtask

    task automatic expand_round_keys();
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        key_words[0] = cur_key_high[63:32];
        key_words[1] = cur_key_high[31:0];
        key_words[2] = cur_key_low[63:32];
        key_words[3] = cur_key_low[31:0];
        for (int n = 4; n < 44; n++) begin
            t = key_words[n-1];
            if (n % 4 == 0) begin
                t = {sub_tab[t[23:16]], sub_tab[t[15:8]], sub_tab[t[7:0]], sub_tab[t[31:24]]};
                t ^= {rc, 24'h0};
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end
            key_words[n] = key_words[n-4] ^ t;
        end
        words_valid = 1'b1;
    endtask

    // state byte index c*4+r; byte 0 is the top of the 128-bit block
    function automatic logic [127:0] mix_in_key(input logic [127:0] s, input int rnd);
        return s ^ {key_words[rnd*4], key_words[rnd*4+1], key_words[rnd*4+2],
                    key_words[rnd*4+3]};
    endfunction

    function automatic logic [127:0] sub_shift_rows(input logic [127:0] s, input bit inv);
        logic [7:0]   b[16];
        logic [7:0]   o[16];
        logic [127:0] r;
        for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
        for (int c = 0; c < 4; c++) begin
            for (int rw = 0; rw < 4; rw++) begin
                if (inv) o[((c+rw)%4)*4+rw] = inv_sub_tab[b[c*4+rw]];
                else     o[c*4+rw] = sub_tab[b[((c+rw)%4)*4+rw]];
            end
        end
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = o[i];
        return r;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input bit inv);
        logic [7:0]   col[4];
        logic [7:0]   m[4];
        logic [7:0]   acc;
        logic [127:0] r;
        if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else     m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) col[k] = s[127-8*(c*4+k) -: 8];
            for (int rw = 0; rw < 4; rw++) begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++) acc ^= gf_mul(col[k], m[(k-rw+4)%4]);
                r[127-8*(c*4+rw) -: 8] = acc;
            end
        end
        return r;
    endfunction

    function automatic t_rsp cipher_block(input t_req q);
        logic [127:0] s;
        t_rsp         o;
        s = {q.data_high, q.data_low};
        if (q.operation == OpEncrypt) begin
            s = mix_in_key(s, 0);
            for (int rnd = 1; rnd < 10; rnd++)
                s = mix_in_key(mix_columns(sub_shift_rows(s, 0), 0), rnd);
            s = mix_in_key(sub_shift_rows(s, 0), 10);
        end else begin
            s = mix_in_key(s, 10);
            for (int rnd = 9; rnd > 0; rnd--)
                s = mix_columns(mix_in_key(sub_shift_rows(s, 1), rnd), 1);
            s = mix_in_key(sub_shift_rows(s, 1), 0);
        end
        o.result_high = s[127:64];
        o.result_low  = s[63:0];
        return o;
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    always @(posedge clk) begin
        t_rsp want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (expected_blocks.size() == 0) begin
                report_mismatch("unexpected result_high", rsp.result_high, 64'h0);
            end else begin
                want = expected_blocks.pop_front();
                blocks_checked++;
                if (rsp.result_high !== want.result_high)
                    report_mismatch("result_high", rsp.result_high, want.result_high);
                if (rsp.result_low !== want.result_low)
                    report_mismatch("result_low", rsp.result_low, want.result_low);
            end
        end
    end

    // receiver stall: random per result, or a long hold-off on request
    initial begin
        int unsigned wait_n;
        forever begin
            @(posedge clk);
            if (hold_long) begin
                rsp_stall <= 1'b1;
                repeat (300) @(posedge clk);
                rsp_stall <= 1'b0;
                hold_long = 1'b0;
            end else if (rsp_gaps && rsp_valid && !rsp_stall) begin
                wait_n = $urandom_range(0, 13);
                if (wait_n > 0) begin
                    rsp_stall <= 1'b1;
                    repeat (wait_n) @(posedge clk);
                    rsp_stall <= 1'b0;
                end
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("watchdog: no progress for %0d cycles", IdleLimit);
            $display("aes128_block_cipher test failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_request(input t_req q, input bit gaps);
        int unsigned gap;
        gap = gaps ? $urandom_range(0, 13) : 0;
        repeat (gap) @(posedge clk);
        if (!words_valid) expand_round_keys();
        expected_blocks.push_back(cipher_block(q));
        req_valid <= 1'b1;
        req <= q;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        req_valid <= 1'b0;
        requests_sent++;
        // the block stays busy on the next cycle anyway
        @(posedge clk);
    endtask

    task automatic drain();
        while (expected_blocks.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
        drain();
        cfg_we <= 1'b1;
        cfg_idx <= CfgKeyHigh;
        cfg_data <= hi;
        @(posedge clk);
        cfg_idx <= CfgKeyLow;
        cfg_data <= lo;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_key_high = hi;
        cur_key_low = lo;
        words_valid = 1'b0;
    endtask

    function automatic t_req make_req(input logic op, input logic [63:0] h,
                                      input logic [63:0] l);
        t_req q;
        q.operation = op;
        q.data_high = h;
        q.data_low  = l;
        return q;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_reset_key();
        // blocks before any key write use the all-zero key
        send_request(make_req(OpEncrypt, '0, '0), 0);
        send_request(make_req(OpDecrypt, '0, '0), 0);
        send_request(make_req(OpEncrypt, '1, '1), 1);
    endtask

    task automatic test_known_vectors();
        write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_request(make_req(OpEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff), 0);
        send_request(make_req(OpDecrypt, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a), 0);
        write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        send_request(make_req(OpEncrypt, 64'h3243f6a8885a308d, 64'h313198a2e0370734), 1);
    endtask

    task automatic test_key_extremes();
        write_key('1, '1);
        send_request(make_req(OpEncrypt, '1, '0), 0);
        send_request(make_req(OpDecrypt, '0, '1), 0);
        // change only one half of the key
        drain();
        cfg_we <= 1'b1;
        cfg_idx <= CfgKeyLow;
        cfg_data <= 64'h0;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_key_low = '0;
        words_valid = 1'b0;
        send_request(make_req(OpEncrypt, 64'h8000000000000001, 64'h8000000000000001), 0);
        send_request(make_req(OpDecrypt, 64'h8000000000000001, 64'h8000000000000001), 0);
    endtask

    task automatic test_random(input int unsigned n, input bit gaps);
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 99) write_key(rand64(), rand64());
            send_request(make_req(1'($urandom_range(0, 1)), rand64(), rand64()), gaps);
        end
    endtask

    task automatic test_back_pressure();
        // hold results off while requests keep coming, pause until empty, then repeat with no result gaps
        hold_long = 1'b1;
        test_random(40, 0);
        drain();
        rsp_gaps = 1'b0;
        test_random(60, 0);
        rsp_gaps = 1'b1;
        drain();
    endtask

    initial begin
        build_sub_tables();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_key();
        test_known_vectors();
        test_key_extremes();
        test_random(700, 1);
        test_back_pressure();
        write_key(rand64(), rand64());
        test_random(600, 1);
        drain();
        $display("covered %0d requests, %0d results checked, over several keys incl. all-0/all-1",
                 requests_sent, blocks_checked);
        $display("both directions with random gaps, long result hold-off and back-to-back");
        if (errors == 0 && expected_blocks.size() == 0) begin
            $display("aes128_block_cipher test passed");
        end else begin
            $display("errors %0d, outstanding %0d", errors, expected_blocks.size());
            $display("aes128_block_cipher test failed");
        end
        $finish;
    end

endmodule
